>>> rtl/core/tle_pkg.sv
package tle_pkg;

    localparam int LINE_BYTES   = 32;
    localparam int HIST_ENTRIES = 5;

    localparam int BYTE_W      = 8;
    localparam int FIELD_LEN_W = 5;
    localparam int LEN_W       = $clog2(LINE_BYTES);
    localparam int SLOT_W      = (HIST_ENTRIES > 1) ? $clog2(HIST_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(HIST_ENTRIES + 1);

    typedef struct packed {
        logic                   req_type;
        logic [BYTE_W-1:0]      rx_byte;
        logic [FIELD_LEN_W-1:0] read_index;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0]      out_byte;
        logic                   is_echo;
        logic                   line_committed;
        logic [FIELD_LEN_W-1:0] committed_length;
        logic                   last;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RD_OUT,
        ST_ECHO,
        ST_RC_LEN,
        ST_MSG,
        ST_RC_RD,
        ST_RC_WR,
        ST_CM_RD,
        ST_CM_WR
    } t_state;

    typedef enum logic [1:0] {
        MSG_ERASE,
        MSG_ENTER,
        MSG_PROMPT,
        MSG_TAIL
    } t_msg;

    typedef enum logic [1:0] {
        OSEL_MSG,
        OSEL_BYTE,
        OSEL_HIST,
        OSEL_READ
    } t_osel;

    typedef struct packed {
        logic  capture;
        logic  hist_rd;
        logic  read_slot;
        logic  esc_open;
        logic  esc_second;
        logic  esc_clear;
        logic  type_char;
        logic  erase;
        logic  down_clear;
        logic  recall_up;
        logic  recall_down;
        logic  rc_len;
        logic  commit_start;
        logic  commit_finish;
        logic  msg_load;
        t_msg  msg_sel;
        logic  edit_rd;
        logic  edit_copy;
        logic  hist_wr;
        logic  idx_inc;
        logic  emit;
        t_osel osel;
        logic  last;
    } t_cmd;

    typedef struct packed {
        logic is_read;
        logic esc_open;
        logic esc_second;
        logic ch_esc;
        logic ch_enter;
        logic ch_erase;
        logic ch_print;
        logic edit_empty;
        logic edit_full;
        logic seq_up;
        logic seq_down;
        logic can_up;
        logic down_recall;
        logic copy_done;
        logic msg_last;
        logic out_free;
    } t_stat;

endpackage

>>> rtl/core/tle_ctrl.sv
module tle_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  tle_pkg::t_stat i_stat,
    output tle_pkg::t_cmd  o_cmd
);
    import tle_pkg::*;

    t_state r_state;
    t_state n_state;
    // Set while the prompt in flight leads into a recall copy.
    logic   r_to_recall;
    logic   n_to_recall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_to_recall <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_to_recall <= n_to_recall;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_to_recall = r_to_recall;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_state = ST_IDLE;
                if (i_stat.is_read) begin
                    n_state = ST_RD_OUT;
                end else if (i_stat.esc_open) begin
                    n_state = ST_IDLE;
                end else if (i_stat.esc_second) begin
                    if (i_stat.seq_up && i_stat.can_up) begin
                        n_state     = ST_RC_LEN;
                        n_to_recall = 1'b1;
                    end else if (i_stat.seq_down) begin
                        n_state     = i_stat.down_recall ? ST_RC_LEN : ST_MSG;
                        n_to_recall = i_stat.down_recall;
                    end
                end else if (i_stat.ch_esc) begin
                    n_state = ST_IDLE;
                end else if (i_stat.ch_enter) begin
                    n_state     = i_stat.edit_empty ? ST_MSG : ST_CM_RD;
                    n_to_recall = 1'b0;
                end else if (i_stat.ch_erase) begin
                    if (!i_stat.edit_empty) begin
                        n_state     = ST_MSG;
                        n_to_recall = 1'b0;
                    end
                end else if (i_stat.ch_print && !i_stat.edit_full) begin
                    n_state = ST_ECHO;
                end
            end
            ST_RD_OUT, ST_ECHO: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_RC_LEN: begin
                n_state = ST_MSG;
            end
            ST_MSG: begin
                if (i_stat.out_free && i_stat.msg_last) begin
                    n_state = r_to_recall ? ST_RC_RD : ST_IDLE;
                end
            end
            ST_RC_RD: begin
                if (i_stat.copy_done) begin
                    n_state     = ST_MSG;
                    n_to_recall = 1'b0;
                end else begin
                    n_state = ST_RC_WR;
                end
            end
            ST_RC_WR: begin
                if (i_stat.out_free) begin
                    n_state = ST_RC_RD;
                end
            end
            ST_CM_RD: begin
                n_state = i_stat.copy_done ? ST_MSG : ST_CM_WR;
            end
            ST_CM_WR: begin
                n_state = ST_CM_RD;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.capture = i_in_valid;
            end
            ST_DECODE: begin
                if (i_stat.is_read) begin
                    o_cmd.hist_rd   = 1'b1;
                    o_cmd.read_slot = 1'b1;
                end else if (i_stat.esc_open) begin
                    o_cmd.esc_second = 1'b1;
                end else if (i_stat.esc_second) begin
                    o_cmd.esc_clear = 1'b1;
                    if (i_stat.seq_up && i_stat.can_up) begin
                        o_cmd.recall_up = 1'b1;
                    end else if (i_stat.seq_down) begin
                        if (i_stat.down_recall) begin
                            o_cmd.recall_down = 1'b1;
                        end else begin
                            o_cmd.down_clear = 1'b1;
                            o_cmd.msg_load   = 1'b1;
                            o_cmd.msg_sel    = MSG_PROMPT;
                        end
                    end
                end else if (i_stat.ch_esc) begin
                    o_cmd.esc_open = 1'b1;
                end else begin
                    o_cmd.esc_clear = 1'b1;
                    if (i_stat.ch_enter) begin
                        if (i_stat.edit_empty) begin
                            o_cmd.msg_load = 1'b1;
                            o_cmd.msg_sel  = MSG_ENTER;
                        end else begin
                            o_cmd.commit_start = 1'b1;
                        end
                    end else if (i_stat.ch_erase) begin
                        if (!i_stat.edit_empty) begin
                            o_cmd.erase    = 1'b1;
                            o_cmd.msg_load = 1'b1;
                            o_cmd.msg_sel  = MSG_ERASE;
                        end
                    end else if (i_stat.ch_print && !i_stat.edit_full) begin
                        o_cmd.type_char = 1'b1;
                    end
                end
            end
            ST_RD_OUT: begin
                o_cmd.emit = i_stat.out_free;
                o_cmd.osel = OSEL_READ;
                o_cmd.last = 1'b1;
            end
            ST_ECHO: begin
                o_cmd.emit = i_stat.out_free;
                o_cmd.osel = OSEL_BYTE;
                o_cmd.last = 1'b1;
            end
            ST_RC_LEN: begin
                o_cmd.rc_len   = 1'b1;
                o_cmd.msg_load = 1'b1;
                o_cmd.msg_sel  = MSG_PROMPT;
            end
            ST_MSG: begin
                o_cmd.emit = i_stat.out_free;
                o_cmd.osel = OSEL_MSG;
                o_cmd.last = i_stat.msg_last && !r_to_recall;
            end
            ST_RC_RD: begin
                if (i_stat.copy_done) begin
                    o_cmd.msg_load = 1'b1;
                    o_cmd.msg_sel  = MSG_TAIL;
                end else begin
                    o_cmd.hist_rd = 1'b1;
                end
            end
            ST_RC_WR: begin
                o_cmd.emit      = i_stat.out_free;
                o_cmd.osel      = OSEL_HIST;
                o_cmd.edit_copy = i_stat.out_free;
                o_cmd.idx_inc   = i_stat.out_free;
            end
            ST_CM_RD: begin
                if (i_stat.copy_done) begin
                    o_cmd.commit_finish = 1'b1;
                    o_cmd.msg_load      = 1'b1;
                    o_cmd.msg_sel       = MSG_ENTER;
                end else begin
                    o_cmd.edit_rd = 1'b1;
                end
            end
            ST_CM_WR: begin
                o_cmd.hist_wr = 1'b1;
                o_cmd.idx_inc = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

>>> rtl/core/tle_dpath.sv
module tle_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tle_pkg::t_in_item i_in_data,
    input  tle_pkg::t_cmd     i_cmd,
    output tle_pkg::t_stat    o_stat,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output tle_pkg::t_out_item o_out_data
);
    import tle_pkg::*;

    localparam int HIST_DEPTH = HIST_ENTRIES * LINE_BYTES;
    localparam int HADDR_W    = $clog2(HIST_DEPTH);
    localparam int SUM_W      = $clog2(2 * HIST_ENTRIES);
    localparam int MPTR_W     = 4;
    localparam int CMP_W      = (LEN_W > FIELD_LEN_W) ? LEN_W : FIELD_LEN_W;

    localparam logic [BYTE_W-1:0] CH_ESC   = 8'h1B;
    localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
    localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7F;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TILDE = 8'h7E;
    localparam logic [BYTE_W-1:0] CH_GT    = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_LBR   = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_UP    = 8'h41;
    localparam logic [BYTE_W-1:0] CH_DOWN  = 8'h42;

    // Echo strings laid end to end: erase, enter, prompt, recall tail.
    localparam logic [MPTR_W-1:0] MI_ERASE  = 4'd0;
    localparam logic [MPTR_W-1:0] MI_ENTER  = 4'd3;
    localparam logic [MPTR_W-1:0] MI_PROMPT = 4'd7;
    localparam logic [MPTR_W-1:0] MI_TAIL   = 4'd10;

    typedef enum logic [1:0] {
        ESC_NONE,
        ESC_OPEN,
        ESC_SECOND
    } t_esc;

    function automatic logic [BYTE_W-1:0] msg_byte(input logic [MPTR_W-1:0] idx);
        logic [BYTE_W-1:0] b;
        case (idx)
            4'd0:    b = CH_BS;
            4'd1:    b = CH_SP;
            4'd2:    b = CH_BS;
            4'd3:    b = CH_CR;
            4'd4:    b = CH_LF;
            4'd5:    b = CH_GT;
            4'd6:    b = CH_SP;
            4'd7:    b = CH_CR;
            4'd8:    b = CH_GT;
            4'd9:    b = CH_SP;
            4'd10:   b = CH_SP;
            4'd11:   b = CH_BS;
            default: b = '0;
        endcase
        return b;
    endfunction

    function automatic logic [HADDR_W-1:0] hist_addr(input logic [SLOT_W-1:0] slot,
                                                     input logic [LEN_W-1:0]  off);
        return HADDR_W'(slot) * HADDR_W'(LINE_BYTES) + HADDR_W'(off);
    endfunction

    logic [BYTE_W-1:0]      r_edit_mem [LINE_BYTES];
    logic [BYTE_W-1:0]      r_hist_mem [HIST_DEPTH];
    logic [LEN_W-1:0]       r_hist_len [HIST_ENTRIES];

    logic                   r_req;
    logic [BYTE_W-1:0]      r_byte;
    logic [FIELD_LEN_W-1:0] r_ridx;
    logic [LEN_W-1:0]       r_edit_len;
    logic [SLOT_W-1:0]      r_newest;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       r_offset;
    t_esc                   r_esc;
    logic [BYTE_W-1:0]      r_esc_first;
    logic [SLOT_W-1:0]      r_slot;
    logic [LEN_W-1:0]       r_clen;
    logic [LEN_W-1:0]       r_idx;
    logic [MPTR_W-1:0]      r_mptr;
    logic [MPTR_W-1:0]      r_mend;
    logic                   r_commit;
    logic [BYTE_W-1:0]      r_edata;
    logic [BYTE_W-1:0]      r_hdata;
    logic                   r_out_valid;
    t_out_item              r_out;

    logic [CNT_W-1:0]       rc_back;
    logic [SUM_W-1:0]       rc_sum;
    logic [SLOT_W-1:0]      rc_slot;
    logic [SLOT_W-1:0]      cm_slot;
    logic [BYTE_W-1:0]      read_val;
    logic [BYTE_W-1:0]      out_byte;
    logic                   out_free;
    logic                   edit_we;
    logic [LEN_W-1:0]       edit_waddr;
    logic [BYTE_W-1:0]      edit_wdata;
    logic [HADDR_W-1:0]     hist_raddr;

    assign out_free = !r_out_valid || !i_out_stall;

    // Slot of the k-th newest line; k-1 never reaches the ring size.
    always_comb begin
        rc_back = i_cmd.recall_up ? r_offset : r_offset - CNT_W'(2);
        rc_sum  = SUM_W'(r_newest) + SUM_W'(HIST_ENTRIES) - SUM_W'(rc_back);
        if (rc_sum >= SUM_W'(HIST_ENTRIES)) begin
            rc_slot = SLOT_W'(rc_sum - SUM_W'(HIST_ENTRIES));
        end else begin
            rc_slot = SLOT_W'(rc_sum);
        end
        if (r_count == '0 || r_newest == SLOT_W'(HIST_ENTRIES - 1)) begin
            cm_slot = '0;
        end else begin
            cm_slot = r_newest + SLOT_W'(1);
        end
    end

    always_comb begin
        if (r_count != '0 && CMP_W'(r_ridx) < CMP_W'(r_hist_len[r_slot])) begin
            read_val = r_hdata;
        end else begin
            read_val = '0;
        end
        case (i_cmd.osel)
            OSEL_MSG:  out_byte = msg_byte(r_mptr);
            OSEL_BYTE: out_byte = r_byte;
            OSEL_HIST: out_byte = r_hdata;
            default:   out_byte = read_val;
        endcase
    end

    always_comb begin
        o_stat             = '0;
        o_stat.is_read     = r_req;
        o_stat.esc_open    = (r_esc == ESC_OPEN);
        o_stat.esc_second  = (r_esc == ESC_SECOND);
        o_stat.ch_esc      = (r_byte == CH_ESC);
        o_stat.ch_enter    = (r_byte == CH_CR) || (r_byte == CH_LF);
        o_stat.ch_erase    = (r_byte == CH_BS) || (r_byte == CH_DEL);
        o_stat.ch_print    = (r_byte >= CH_SP) && (r_byte <= CH_TILDE);
        o_stat.edit_empty  = (r_edit_len == '0);
        o_stat.edit_full   = (r_edit_len >= LEN_W'(LINE_BYTES - 1));
        o_stat.seq_up      = (r_esc_first == CH_LBR) && (r_byte == CH_UP);
        o_stat.seq_down    = (r_esc_first == CH_LBR) && (r_byte == CH_DOWN);
        o_stat.can_up      = (r_offset < r_count);
        o_stat.down_recall = (r_offset > CNT_W'(1));
        o_stat.copy_done   = (r_idx == r_clen);
        o_stat.msg_last    = (r_mptr == r_mend);
        o_stat.out_free    = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edit_len  <= '0;
            r_newest    <= '0;
            r_count     <= '0;
            r_offset    <= '0;
            r_esc       <= ESC_NONE;
            r_esc_first <= '0;
            r_commit    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < HIST_ENTRIES; i++) begin
                r_hist_len[i] <= '0;
            end
        end else begin
            if (i_cmd.esc_open) begin
                r_esc <= ESC_OPEN;
            end else if (i_cmd.esc_second) begin
                r_esc       <= ESC_SECOND;
                r_esc_first <= r_byte;
            end else if (i_cmd.esc_clear) begin
                r_esc <= ESC_NONE;
            end

            if (i_cmd.type_char) begin
                r_edit_len <= r_edit_len + LEN_W'(1);
            end else if (i_cmd.erase) begin
                r_edit_len <= r_edit_len - LEN_W'(1);
            end else if (i_cmd.down_clear || i_cmd.commit_finish) begin
                r_edit_len <= '0;
            end else if (i_cmd.rc_len) begin
                r_edit_len <= r_hist_len[r_slot];
            end

            if (i_cmd.recall_up) begin
                r_offset <= r_offset + CNT_W'(1);
            end else if (i_cmd.recall_down) begin
                r_offset <= r_offset - CNT_W'(1);
            end else if (i_cmd.down_clear || i_cmd.commit_finish) begin
                r_offset <= '0;
            end

            if (i_cmd.commit_finish) begin
                r_hist_len[r_slot] <= r_clen;
                r_newest           <= r_slot;
                if (r_count != CNT_W'(HIST_ENTRIES)) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end

            if (i_cmd.capture) begin
                r_commit <= 1'b0;
            end else if (i_cmd.commit_finish) begin
                r_commit <= 1'b1;
            end

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req  <= i_in_data.req_type;
            r_byte <= i_in_data.rx_byte;
            r_ridx <= i_in_data.read_index;
        end

        if (i_cmd.read_slot) begin
            r_slot <= r_newest;
        end else if (i_cmd.recall_up || i_cmd.recall_down) begin
            r_slot <= rc_slot;
        end else if (i_cmd.commit_start) begin
            r_slot <= cm_slot;
        end

        if (i_cmd.commit_start) begin
            r_clen <= r_edit_len;
            r_idx  <= '0;
        end else if (i_cmd.rc_len) begin
            r_clen <= r_hist_len[r_slot];
            r_idx  <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + LEN_W'(1);
        end

        if (i_cmd.msg_load) begin
            unique case (i_cmd.msg_sel)
                MSG_ERASE: begin
                    r_mptr <= MI_ERASE;
                    r_mend <= MI_ENTER - MPTR_W'(1);
                end
                MSG_ENTER: begin
                    r_mptr <= MI_ENTER;
                    r_mend <= MI_PROMPT - MPTR_W'(1);
                end
                MSG_PROMPT: begin
                    r_mptr <= MI_PROMPT;
                    r_mend <= MI_TAIL - MPTR_W'(1);
                end
                MSG_TAIL: begin
                    r_mptr <= MI_TAIL;
                    r_mend <= MI_TAIL + MPTR_W'(1);
                end
                default: begin
                    r_mptr <= MI_PROMPT;
                    r_mend <= MI_TAIL - MPTR_W'(1);
                end
            endcase
        end else if (i_cmd.emit && i_cmd.osel == OSEL_MSG) begin
            r_mptr <= r_mptr + MPTR_W'(1);
        end

        if (i_cmd.emit) begin
            r_out.out_byte         <= out_byte;
            r_out.is_echo          <= (i_cmd.osel != OSEL_READ);
            r_out.line_committed   <= r_commit;
            r_out.committed_length <= r_commit ? FIELD_LEN_W'(r_clen) : '0;
            r_out.last             <= i_cmd.last;
        end
    end

    // Edit line store: typed bytes land at the end, recalled bytes by position.
    always_comb begin
        edit_we    = i_cmd.type_char || i_cmd.edit_copy;
        edit_waddr = i_cmd.type_char ? r_edit_len : r_idx;
        edit_wdata = i_cmd.type_char ? r_byte : r_hdata;
        hist_raddr = r_req ? hist_addr(r_newest, LEN_W'(r_ridx)) : hist_addr(r_slot, r_idx);
    end

    always_ff @(posedge i_clk) begin
        if (edit_we) begin
            r_edit_mem[edit_waddr] <= edit_wdata;
        end
        if (i_cmd.edit_rd) begin
            r_edata <= r_edit_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.hist_wr) begin
            r_hist_mem[hist_addr(r_slot, r_idx)] <= r_edata;
        end
        if (i_cmd.hist_rd) begin
            r_hdata <= r_hist_mem[hist_raddr];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> rtl/core/terminal_line_editor_history.sv
// Channel   Direction  Handshake                 Payload
// request   in         i_in_valid / o_in_stall   i_in_data  (t_in_item)
// result    out        o_out_valid / i_out_stall o_out_data (t_out_item)
//
// One request is handled at a time. A printable byte or a read yields one result; an
// erase or an empty enter yields an echo string, and the enter of a line or a recall
// also copies it byte by byte between the line stores, each byte in a read state and
// then a write state. Each result waits in the output register while the far side
// stalls, and the sequence halts until it is taken. Reset is synchronous and
// clears all control state at once; the line stores need no clearing pass.
module terminal_line_editor_history (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  tle_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tle_pkg::t_out_item o_out_data
);
    import tle_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    tle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tle_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // While a new request may enter, only the final result of the previous one may wait.
    a_idle_only_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_in_stall && o_out_valid) |-> o_out_data.last)
        else $error("result other than the last one pending while idle");

    a_emit_when_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> stat.out_free)
        else $error("output register overwritten");

    a_read_single : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.is_echo) |->
            (o_out_data.last && !o_out_data.line_committed))
        else $error("read answer malformed");

    a_commit_len : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.line_committed) |->
            (o_out_data.committed_length != '0))
        else $error("committed line with zero length");

endmodule
